/* src/csp_pkg.sv */
// Shared types, constants and register map of the cascaded steering controller.
package csp_pkg;

   localparam int GAIN_FRAC_BITS = 8;
   localparam int CHUNK_W        = 17;
   localparam int GAIN_W         = 24;
   localparam int MUL_A_W        = 25;
   localparam int MUL_B_W        = 18;
   localparam int MUL_P_W        = MUL_A_W + MUL_B_W;
   localparam int SUM_W          = 64;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 31;
   localparam int STEP_W         = 5;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_DEV_KP,
      REG_DEV_KD,
      REG_DEV_KP2,
      REG_DEV_MAX,
      REG_ANG_KP,
      REG_ANG_KI,
      REG_ANG_KD,
      REG_ANG_LIMIT
   } reg_index_type;

   localparam logic [23:0] RST_DEV_KP    = 24'd120320;
   localparam logic [23:0] RST_DEV_KD    = 24'd171520;
   localparam logic [23:0] RST_DEV_KP2   = 24'd0;
   localparam logic [30:0] RST_DEV_MAX   = 31'd800;
   localparam logic [23:0] RST_ANG_KP    = 24'd2048;
   localparam logic [23:0] RST_ANG_KI    = 24'd26;
   localparam logic [23:0] RST_ANG_KD    = 24'd0;
   localparam logic [14:0] RST_ANG_LIMIT = 15'd6000;

   typedef struct packed {
      logic [23:0] dev_kp;
      logic [23:0] dev_kd;
      logic [23:0] dev_kp2;
      logic [30:0] dev_max;
      logic [23:0] ang_kp;
      logic [23:0] ang_ki;
      logic [23:0] ang_kd;
      logic [14:0] ang_limit;
   } cfg_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_FRAC,
      ACC_HIGH
   } acc_kind_type;

   typedef struct packed {
      logic                        clear;
      acc_kind_type                kind;
      logic signed [MUL_A_W-1:0]   op_a;
      logic signed [MUL_B_W-1:0]   op_b;
   } mac_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

endpackage

/* src/csp_regs.sv */
// Configuration register file of the cascaded steering controller.
module csp_regs import csp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dev_kp    <= RST_DEV_KP;
         cfg_ff.dev_kd    <= RST_DEV_KD;
         cfg_ff.dev_kp2   <= RST_DEV_KP2;
         cfg_ff.dev_max   <= RST_DEV_MAX;
         cfg_ff.ang_kp    <= RST_ANG_KP;
         cfg_ff.ang_ki    <= RST_ANG_KI;
         cfg_ff.ang_kd    <= RST_ANG_KD;
         cfg_ff.ang_limit <= RST_ANG_LIMIT;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_DEV_KP:    cfg_ff.dev_kp    <= csr_wdata[23:0];
            REG_DEV_KD:    cfg_ff.dev_kd    <= csr_wdata[23:0];
            REG_DEV_KP2:   cfg_ff.dev_kp2   <= csr_wdata[23:0];
            REG_DEV_MAX:   cfg_ff.dev_max   <= csr_wdata[30:0];
            REG_ANG_KP:    cfg_ff.ang_kp    <= csr_wdata[23:0];
            REG_ANG_KI:    cfg_ff.ang_ki    <= csr_wdata[23:0];
            REG_ANG_KD:    cfg_ff.ang_kd    <= csr_wdata[23:0];
            REG_ANG_LIMIT: cfg_ff.ang_limit <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/csp_mac.sv */
// Shared 25x18 signed multiplier with a shifting 64-bit accumulator.
module csp_mac import csp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  mac_req_type               req,
   output logic signed [MUL_P_W-1:0] prod,
   output logic signed [SUM_W-1:0]   sum
);

   logic signed [MUL_P_W-1:0] prod_ff;
   acc_kind_type              kind_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [SUM_W-1:0]   sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= ACC_NONE;
      end else begin
         kind_ff <= req.kind;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= req.op_a * req.op_b;
      sum_ff  <= sum_in;
   end

   // A wide operand is split into a low unsigned chunk and a high signed chunk.
   // Since the low partial product is never negative, the floor shift of the
   // whole product equals the high part shifted left plus the low part floored.
   always_comb begin
      case (kind_ff)
         ACC_FRAC: sum_in = sum_ff + SUM_W'(prod_ff >>> GAIN_FRAC_BITS);
         ACC_HIGH: sum_in = sum_ff + (SUM_W'(prod_ff) <<< (CHUNK_W - GAIN_FRAC_BITS));
         default:  sum_in = sum_ff;
      endcase
      if (req.clear) begin
         sum_in = '0;
      end
   end

   assign prod = prod_ff;
   assign sum  = sum_ff;

endmodule

/* src/csp_ctrl.sv */
// Sequencer and loop state of the cascaded steering controller.
module csp_ctrl import csp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      req_valid,
   input  logic signed [15:0]        req_offset,
   input  logic signed [15:0]        req_yaw,
   output logic                      req_ready,
   output mac_req_type               mac_req,
   input  logic signed [MUL_P_W-1:0] prod,
   input  logic signed [SUM_W-1:0]   sum,
   input  logic                      out_free,
   output logic                      res_valid,
   output logic signed [31:0]        res_target,
   output logic signed [15:0]        res_drive
);

   localparam logic [STEP_W-1:0] STEP_SQUARE    = 5'd0;
   localparam logic [STEP_W-1:0] STEP_DEV_P     = 5'd1;
   localparam logic [STEP_W-1:0] STEP_DEV_D     = 5'd2;
   localparam logic [STEP_W-1:0] STEP_DEV_P2_LO = 5'd3;
   localparam logic [STEP_W-1:0] STEP_DEV_P2_HI = 5'd4;
   localparam logic [STEP_W-1:0] STEP_TARGET    = 5'd6;
   localparam logic [STEP_W-1:0] STEP_ERROR     = 5'd7;
   localparam logic [STEP_W-1:0] STEP_ANG_I_LO  = 5'd8;
   localparam logic [STEP_W-1:0] STEP_ANG_I_HI  = 5'd9;
   localparam logic [STEP_W-1:0] STEP_ANG_P_LO  = 5'd10;
   localparam logic [STEP_W-1:0] STEP_ANG_P_HI  = 5'd11;
   localparam logic [STEP_W-1:0] STEP_ANG_D_LO  = 5'd12;
   localparam logic [STEP_W-1:0] STEP_ANG_D_HI  = 5'd13;
   localparam logic [STEP_W-1:0] STEP_INC       = 5'd15;
   localparam logic [STEP_W-1:0] STEP_LAST      = 5'd16;

   state_type                state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;

   logic signed [16:0]       e_ff;
   logic signed [15:0]       yaw_ff;
   logic signed [31:0]       m0_ff;
   logic signed [31:0]       target_ff;
   logic signed [32:0]       ei_ff;
   logic signed [33:0]       d1_ff;
   logic signed [34:0]       d2_ff;
   logic signed [31:0]       inc_ff;
   logic signed [15:0]       drv_ff;
   logic signed [16:0]       prev_e_ff;
   logic signed [32:0]       e1_ff;
   logic signed [32:0]       e2_ff;
   logic signed [15:0]       acc_ff;

   logic [16:0]              mag_c;
   logic signed [17:0]       de_c;
   logic signed [31:0]       sum_sat_c;
   logic signed [31:0]       dmax_c;
   logic signed [31:0]       target_c;
   logic signed [32:0]       ei_c;
   logic signed [33:0]       d1_c;
   logic signed [34:0]       d2_c;
   logic signed [32:0]       drv_sum_c;
   logic signed [32:0]       lim_c;
   logic signed [15:0]       drv_c;
   logic                     run_c;

   // Arithmetic around the shared multiplier.
   always_comb begin
      mag_c  = e_ff[16] ? 17'(-e_ff) : 17'(e_ff);
      de_c   = 18'(e_ff) - 18'(prev_e_ff);
      if (sum > SUM_W'(S32_MAX)) begin
         sum_sat_c = S32_MAX;
      end else if (sum < SUM_W'(S32_MIN)) begin
         sum_sat_c = S32_MIN;
      end else begin
         sum_sat_c = 32'(sum);
      end
      dmax_c   = signed'({1'b0, cfg.dev_max});
      target_c = (sum_sat_c > dmax_c) ? dmax_c : sum_sat_c;
      ei_c     = 33'(target_ff) - 33'(yaw_ff);
      d1_c     = 34'(ei_ff) - 34'(e1_ff);
      d2_c     = 35'(ei_ff) - (35'(e1_ff) <<< 1) + 35'(e2_ff);
      drv_sum_c = 33'(acc_ff) + 33'(inc_ff);
      lim_c     = signed'({18'b0, cfg.ang_limit});
      if (drv_sum_c > lim_c) begin
         drv_c = 16'(lim_c);
      end else if (drv_sum_c < -lim_c) begin
         drv_c = 16'(-lim_c);
      end else begin
         drv_c = 16'(drv_sum_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      run_c     = 1'b0;
      mac_req   = '{clear: 1'b0, kind: ACC_NONE, op_a: '0, op_b: '0};
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            run_c   = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (run_c) begin
         case (step_ff)
            STEP_SQUARE: begin
               mac_req.clear = 1'b1;
               mac_req.op_a  = signed'({8'b0, mag_c});
               mac_req.op_b  = 18'(e_ff);
            end
            STEP_DEV_P: begin
               mac_req.kind = ACC_FRAC;
               mac_req.op_a = signed'({1'b0, cfg.dev_kp});
               mac_req.op_b = 18'(e_ff);
            end
            STEP_DEV_D: begin
               mac_req.kind = ACC_FRAC;
               mac_req.op_a = signed'({1'b0, cfg.dev_kd});
               mac_req.op_b = de_c;
            end
            STEP_DEV_P2_LO: begin
               mac_req.kind = ACC_FRAC;
               mac_req.op_a = signed'({1'b0, cfg.dev_kp2});
               mac_req.op_b = signed'({1'b0, m0_ff[16:0]});
            end
            STEP_DEV_P2_HI: begin
               mac_req.kind = ACC_HIGH;
               mac_req.op_a = signed'({1'b0, cfg.dev_kp2});
               mac_req.op_b = 18'(signed'(m0_ff[31:17]));
            end
            STEP_TARGET: begin
               mac_req.clear = 1'b1;
            end
            STEP_ANG_I_LO: begin
               mac_req.kind = ACC_FRAC;
               mac_req.op_a = signed'({1'b0, cfg.ang_ki});
               mac_req.op_b = signed'({1'b0, ei_ff[16:0]});
            end
            STEP_ANG_I_HI: begin
               mac_req.kind = ACC_HIGH;
               mac_req.op_a = signed'({1'b0, cfg.ang_ki});
               mac_req.op_b = 18'(signed'(ei_ff[32:17]));
            end
            STEP_ANG_P_LO: begin
               mac_req.kind = ACC_FRAC;
               mac_req.op_a = signed'({1'b0, cfg.ang_kp});
               mac_req.op_b = signed'({1'b0, d1_ff[16:0]});
            end
            STEP_ANG_P_HI: begin
               mac_req.kind = ACC_HIGH;
               mac_req.op_a = signed'({1'b0, cfg.ang_kp});
               mac_req.op_b = 18'(signed'(d1_ff[33:17]));
            end
            STEP_ANG_D_LO: begin
               mac_req.kind = ACC_FRAC;
               mac_req.op_a = signed'({1'b0, cfg.ang_kd});
               mac_req.op_b = signed'({1'b0, d2_ff[16:0]});
            end
            STEP_ANG_D_HI: begin
               mac_req.kind = ACC_HIGH;
               mac_req.op_a = signed'({1'b0, cfg.ang_kd});
               mac_req.op_b = signed'(d2_ff[34:17]);
            end
            default: begin
            end
         endcase
      end
   end

   // Working registers of one control tick.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         e_ff   <= -17'(req_offset);
         yaw_ff <= req_yaw;
      end
      if (run_c) begin
         case (step_ff)
            STEP_DEV_P:    m0_ff     <= 32'(prod);
            STEP_TARGET:   target_ff <= target_c;
            STEP_ERROR:    ei_ff     <= ei_c;
            STEP_ANG_I_LO: begin
               d1_ff <= d1_c;
               d2_ff <= d2_c;
            end
            STEP_INC:      inc_ff    <= sum_sat_c;
            STEP_LAST:     drv_ff    <= drv_c;
            default: begin
            end
         endcase
      end
   end

   // Loop history carried from tick to tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_e_ff <= '0;
         e1_ff     <= '0;
         e2_ff     <= '0;
         acc_ff    <= '0;
      end else if (run_c && step_ff == STEP_LAST) begin
         prev_e_ff <= e_ff;
         e2_ff     <= e1_ff;
         e1_ff     <= ei_ff;
         acc_ff    <= drv_c;
      end
   end

   assign res_target = target_ff;
   assign res_drive  = drv_ff;

endmodule

/* src/cascaded_steering_pid.sv */
// Cascaded steering controller: an outer position loop on lateral offset sets the yaw-rate
// target of an inner incremental loop, and each input word yields one result word. All
// eleven products of a tick go through one shared 25x18 multiplier under a step counter,
// so a word is taken, worked through the steps, handed to the output register, and only
// then is the block ready for the next word. The output register holds a result until it
// is taken while the next word is already being worked.
// Configuration takes effect at once; the user must write it only while idle (unenforced).
module cascaded_steering_pid import csp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // lateral_offset[15:0], yaw_rate[31:16]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // steer_target[31:0], drive[47:32]
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                   cfg;
   mac_req_type               mac_req;
   logic signed [MUL_P_W-1:0] prod;
   logic signed [SUM_W-1:0]   sum;
   logic                      out_free;
   logic                      res_valid;
   logic signed [31:0]        res_target;
   logic signed [15:0]        res_drive;

   logic                      rsp_valid_ff;
   logic [31:0]               target_ff;
   logic [15:0]               drive_ff;

   csp_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   csp_mac u_mac (
      .clock (clock),
      .reset (reset),
      .req   (mac_req),
      .prod  (prod),
      .sum   (sum)
   );

   csp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_tvalid),
      .req_offset (signed'(req_tdata[15:0])),
      .req_yaw    (signed'(req_tdata[31:16])),
      .req_ready  (req_tready),
      .mac_req    (mac_req),
      .prod       (prod),
      .sum        (sum),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res_target (res_target),
      .res_drive  (res_drive)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         target_ff <= res_target;
         drive_ff  <= res_drive;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {drive_ff, target_ff};

endmodule

/* src/csp_checker.sv */
// Port-level checks of the cascaded steering controller, bound to the top level.
module csp_checker import csp_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [47:0]           rsp_tdata
);

   // A word waiting at the output keeps its value until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // The sequencer keeps the input closed for the whole tick.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##16 !req_tready)
      else $error("input reopened before the tick finished");

   // The drive clamp is symmetric, so the most negative code never shows.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:32] != 16'h8000)
      else $error("drive outside the symmetric clamp");

   // Reset empties the output register.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind cascaded_steering_pid csp_checker u_csp_checker (.*);

/* test/tb_top.sv */
// Self-checking testbench of the cascaded steering controller with a built-in predictor.
`timescale 1ns / 100ps

module tb_top;
   import csp_pkg::*;

   typedef struct {
      logic signed [31:0] target;
      logic signed [15:0] drive;
   } steer_word_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;   // lateral_offset[15:0], yaw_rate[31:16]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [47:0]           rsp_tdata;         // steer_target[31:0], drive[47:32]
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Mirror of the register file and of the loop history.
   cfg_type               cfg;
   logic signed [16:0]    offset_err_prev;
   logic signed [32:0]    yaw_err_prev;
   logic signed [32:0]    yaw_err_prev2;
   logic signed [15:0]    drive_acc;

   steer_word_type        pending_steer[$];
   int unsigned           bad_words  = 0;
   bit                    gaps_on    = 1'b1;

   cascaded_steering_pid uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic longint clip_s32(input longint v);
      if (v > longint'(S32_MAX)) return longint'(S32_MAX);
      if (v < longint'(S32_MIN)) return longint'(S32_MIN);
      return v;
   endfunction

   // Works out one control tick and queues the word the block should return for it.
   function automatic void predict_steer(input logic signed [15:0] offset,
                                         input logic signed [15:0] yaw);
      longint         e, mag, tgt, ei, e1, e2, inc, drv, lim;
      steer_word_type w;
      e   = -longint'(offset);
      mag = (e < 0) ? -e : e;
      tgt = ((longint'(cfg.dev_kp2) * (mag * e)) >>> GAIN_FRAC_BITS)
          + ((longint'(cfg.dev_kp) * e) >>> GAIN_FRAC_BITS)
          + ((longint'(cfg.dev_kd) * (e - longint'(offset_err_prev))) >>> GAIN_FRAC_BITS);
      tgt = clip_s32(tgt);
      if (tgt > longint'(cfg.dev_max)) tgt = longint'(cfg.dev_max);
      offset_err_prev = e[16:0];

      e1  = longint'(yaw_err_prev);
      e2  = longint'(yaw_err_prev2);
      ei  = tgt - longint'(yaw);
      inc = ((longint'(cfg.ang_kp) * (ei - e1)) >>> GAIN_FRAC_BITS)
          + ((longint'(cfg.ang_ki) * ei) >>> GAIN_FRAC_BITS)
          + ((longint'(cfg.ang_kd) * (ei - 2 * e1 + e2)) >>> GAIN_FRAC_BITS);
      inc = clip_s32(inc);
      yaw_err_prev2 = yaw_err_prev;
      yaw_err_prev  = ei[32:0];

      lim = longint'(cfg.ang_limit);
      drv = longint'(drive_acc) + inc;
      if (drv > lim) drv = lim;
      if (drv < -lim) drv = -lim;
      drive_acc = drv[15:0];

      w.target = tgt[31:0];
      w.drive  = drv[15:0];
      pending_steer.push_back(w);
   endfunction

   // Result side: random back-pressure unless the quiet stretch is running.
   always @(negedge clock) begin
      rsp_tready <= !gaps_on || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin
      steer_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_steer.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
               $display("unexpected result word: target %0d drive %0d",
                        $signed(rsp_tdata[31:0]), $signed(rsp_tdata[47:32]));
         end else begin
            w = pending_steer.pop_front();
            if (rsp_tdata[31:0] !== w.target) begin
               bad_words++;
               if (bad_words <= 10)
                  $display("steer_target: expected %0d, got %0d",
                           w.target, $signed(rsp_tdata[31:0]));
            end
            if (rsp_tdata[47:32] !== w.drive) begin
               bad_words++;
               if (bad_words <= 10)
                  $display("drive: expected %0d, got %0d",
                           w.drive, $signed(rsp_tdata[47:32]));
            end
         end
      end
   end

   task automatic send_word(input logic signed [15:0] offset,
                            input logic signed [15:0] yaw);
      if (gaps_on && $urandom_range(99) < 12)
         repeat ($urandom_range(1, 24)) @(negedge clock);
      req_tdata  = {yaw, offset};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_steer(offset, yaw);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         REG_DEV_KP:    cfg.dev_kp    = val[23:0];
         REG_DEV_KD:    cfg.dev_kd    = val[23:0];
         REG_DEV_KP2:   cfg.dev_kp2   = val[23:0];
         REG_DEV_MAX:   cfg.dev_max   = val[30:0];
         REG_ANG_KP:    cfg.ang_kp    = val[23:0];
         REG_ANG_KI:    cfg.ang_ki    = val[23:0];
         REG_ANG_KD:    cfg.ang_kd    = val[23:0];
         REG_ANG_LIMIT: cfg.ang_limit = val[14:0];
         default: ;
      endcase
   endtask

   // Registers may only change once the last word is out and the pipeline is empty.
   task automatic wait_idle;
      while (pending_steer.size() != 0) @(posedge clock);
      @(negedge clock);
      repeat (24) @(negedge clock);
   endtask

   task automatic test_reset_defaults;
      send_word(16'sh0000, 16'sh0000);
      send_word(16'sh8000, 16'sh0000);
      send_word(16'sh7FFF, 16'sh0000);
      send_word(-16'sd1, 16'sd1);
      send_word(16'sd1, -16'sd1);
      send_word(16'sh0000, 16'sh7FFF);
      send_word(16'sh0000, 16'sh8000);
      send_word(16'sd200, -16'sd50);
      wait_idle();
   endtask

   // Full-scale gains drive both loops into 32-bit saturation in both directions.
   task automatic test_saturation;
      for (int i = 0; i < 8; i++) write_reg(reg_index_type'(i), '1);
      send_word(16'sh8000, 16'sh8000);
      send_word(16'sh7FFF, 16'sh7FFF);
      send_word(16'sh8000, 16'sh7FFF);
      send_word(16'sh7FFF, 16'sh8000);
      send_word(16'sh0000, 16'sh0000);
      send_word(-16'sd1, -16'sd1);
      wait_idle();
   endtask

   task automatic test_zero_limit;
      write_reg(REG_ANG_LIMIT, '0);
      write_reg(REG_DEV_MAX, '0);
      write_reg(REG_DEV_KP2, '0);
      send_word(16'sd100, -16'sd100);
      send_word(-16'sd100, 16'sd100);
      send_word(16'sh8000, 16'sh0000);
      send_word(16'sd5, 16'sd5);
      wait_idle();
   endtask

   task automatic shuffle_gains;
      logic [CSR_DATA_W-1:0] val;
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(7))
            0:       val = '0;
            1:       val = '1;
            2:       val = CSR_DATA_W'($urandom());
            default: begin
               if (reg_index_type'(i) == REG_DEV_MAX)
                  val = CSR_DATA_W'($urandom_range(40000));
               else if (reg_index_type'(i) == REG_ANG_LIMIT)
                  val = CSR_DATA_W'($urandom_range(32767));
               else if (reg_index_type'(i) == REG_DEV_KP2)
                  val = CSR_DATA_W'($urandom_range(64));
               else
                  val = CSR_DATA_W'($urandom_range(1 << 17));
            end
         endcase
         write_reg(reg_index_type'(i), val);
      end
   endtask

   task automatic test_random_phases;
      logic signed [15:0] offset, yaw;
      for (int phase = 0; phase < 5; phase++) begin
         shuffle_gains();
         // The middle phase runs without any idling on either side.
         gaps_on = (phase != 2);
         for (int n = 0; n < 150; n++) begin
            offset = ($urandom_range(9) < 3) ? 16'($urandom()) : 16'($urandom_range(1200) - 600);
            yaw    = ($urandom_range(9) < 3) ? 16'($urandom()) : 16'($urandom_range(2000) - 1000);
            send_word(offset, yaw);
         end
         wait_idle();
         gaps_on = 1'b1;
      end
   endtask

   initial begin
      cfg = '{dev_kp: RST_DEV_KP, dev_kd: RST_DEV_KD, dev_kp2: RST_DEV_KP2,
              dev_max: RST_DEV_MAX, ang_kp: RST_ANG_KP, ang_ki: RST_ANG_KI,
              ang_kd: RST_ANG_KD, ang_limit: RST_ANG_LIMIT};
      offset_err_prev = '0;
      yaw_err_prev    = '0;
      yaw_err_prev2   = '0;
      drive_acc       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_saturation();
      test_zero_limit();
      test_random_phases();

      for (int n = 0; n < 4000 && pending_steer.size() != 0; n++) @(posedge clock);
      repeat (24) @(negedge clock);
      bad_words += pending_steer.size();
      if (bad_words == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
